// File: design/rms_pkg.sv
// Shared types and constants for the rate-monotonic task scheduler.
// No dependencies; imported by every module of the block.
package rms_pkg;
    localparam int MaxTasks   = 16;
    localparam int SlotW      = $clog2(MaxTasks);
    localparam int IdW        = 22;
    localparam int PerW       = 16;
    localparam int CompW      = 16;
    localparam int UtilW      = 30;
    localparam int TotW       = 35;
    localparam int TimeW      = 48;
    localparam int BoundW     = 14;
    localparam int QDepth     = 2;
    localparam logic [BoundW-1:0] UtilReset = 14'd6930;
    localparam logic [13:0]       UtilScale = 14'd10000;

    typedef enum logic [1:0] {
        OP_REG   = 2'd0,
        OP_YIELD = 2'd1,
        OP_DEREG = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_REFUSED  = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_ZERO     = 3'd4,
        ST_LATE     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        MODE_READY = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_SLEEP = 2'd2
    } mode_t;

    // Classified command handed from front to back.
    typedef struct packed {
        op_t              op;
        logic [IdW-1:0]   task_id;
        logic [PerW-1:0]  period;
        logic [UtilW-1:0] util;
        logic             zero_period;
    } cmd_t;
endpackage

// File: design/rms_front.sv
// Front end: accepts items and computes the admission utilization with a
// bit-serial divider. Depends on rms_pkg.
module rms_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           in_op,
    input  logic [rms_pkg::IdW-1:0]   in_id,
    input  logic [rms_pkg::PerW-1:0]  in_period,
    input  logic [rms_pkg::CompW-1:0] in_comp,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output rms_pkg::cmd_t        cmd
);
    import rms_pkg::*;

    localparam int NumW = 30;
    localparam int CntW = $clog2(NumW + 1);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_OUT  = 3'b100
    } fstate_t;

    fstate_t          state_reg, state_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic [NumW-1:0]  num_reg, num_next;
    logic [PerW:0]    rem_reg, rem_next;
    cmd_t             cmd_reg, cmd_next;
    logic [PerW:0]    rem_sh;

    assign in_ready  = (state_reg == F_IDLE);
    assign cmd_valid = (state_reg == F_OUT);
    assign cmd       = cmd_reg;
    assign rem_sh    = {rem_reg[PerW-1:0], num_reg[NumW-1]};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        cmd_next   = cmd_reg;
        case (state_reg)
            F_IDLE: begin
                if (in_valid) begin
                    cmd_next.op          = op_t'(in_op);
                    cmd_next.task_id     = in_id;
                    cmd_next.period      = in_period;
                    cmd_next.util        = '0;
                    cmd_next.zero_period = (in_period == '0);
                    num_next = NumW'(in_comp) * NumW'(UtilScale);
                    rem_next = '0;
                    cnt_next = CntW'(NumW);
                    state_next = (op_t'(in_op) == OP_REG && in_period != '0) ? F_DIV : F_OUT;
                end
            end
            F_DIV: begin
                // restoring division, one quotient bit per cycle
                if (rem_sh >= {1'b0, cmd_reg.period}) begin
                    rem_next = rem_sh - {1'b0, cmd_reg.period};
                    cmd_next.util = {cmd_reg.util[UtilW-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    cmd_next.util = {cmd_reg.util[UtilW-2:0], 1'b0};
                end
                num_next = {num_reg[NumW-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CntW'(1)) state_next = F_OUT;
            end
            F_OUT: begin
                if (cmd_ready) state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        cmd_reg <= cmd_next;
    end

    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == F_DIV) |-> (cnt_reg != '0))
        else $error("divider count underflow");
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == F_DIV) |-> (rem_reg < {1'b0, cmd_reg.period}))
        else $error("remainder out of range");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_valid && !cmd_ready) |=> $stable(cmd_reg))
        else $error("command changed while waiting");
endmodule

// File: design/rms_queue.sv
// Short command queue between the front end and the task engine.
// Depends on rms_pkg.
module rms_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  rms_pkg::cmd_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output rms_pkg::cmd_t rd_data
);
    import rms_pkg::*;

    localparam int PtrW = $clog2(QDepth);

    cmd_t            mem [QDepth];
    logic [PtrW-1:0] wp_reg, rp_reg;
    logic [PtrW:0]   cnt_reg;
    logic            wr_fire, rd_fire;

    assign wr_ready = (cnt_reg != (PtrW+1)'(QDepth));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem[rp_reg];
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (wr_fire) mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_fire) wp_reg <= wp_reg + 1'b1;
            if (rd_fire) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PtrW+1)'(wr_fire) - (PtrW+1)'(rd_fire);
        end
    end

    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (PtrW+1)'(QDepth))
        else $error("queue overflow");
    a_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0 || cnt_reg == (PtrW+1)'(QDepth)) |-> (wp_reg == rp_reg))
        else $error("queue pointers disagree with count");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0 && !wr_fire) |=> !rd_valid)
        else $error("queue read from empty");
endmodule

// File: design/rms_engine.sv
// Task engine: carries out commands on the task table, one slot per cycle,
// then dispatches and emits the result. Depends on rms_pkg.
module rms_engine (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [rms_pkg::BoundW-1:0] util_bound,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  rms_pkg::cmd_t         cmd,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic [31:0]           res_data
);
    import rms_pkg::*;

    typedef enum logic [5:0] {
        E_IDLE  = 6'b000001,
        E_SCAN  = 6'b000010,
        E_EXEC  = 6'b000100,
        E_DISP  = 6'b001000,
        E_PICK  = 6'b010000,
        E_OUT   = 6'b100000
    } estate_t;

    estate_t          state_reg;
    cmd_t             c_reg;
    logic [SlotW:0]   idx_reg;
    logic             hit_reg;
    logic [SlotW-1:0] hit_slot_reg;
    logic             free_reg;
    logic [SlotW-1:0] free_slot_reg;
    logic             best_reg;
    logic [SlotW-1:0] best_slot_reg;
    logic [PerW-1:0]  best_per_reg;
    status_t          st_reg;
    logic             sw_reg;
    logic [31:0]      res_reg;

    logic             valid_reg   [MaxTasks];
    logic             started_reg [MaxTasks];
    logic             armed_reg   [MaxTasks];
    mode_t            mode_reg    [MaxTasks];
    logic [IdW-1:0]   id_reg      [MaxTasks];
    logic [PerW-1:0]  per_reg     [MaxTasks];
    logic [UtilW-1:0] util_reg    [MaxTasks];
    logic [TimeW-1:0] dl_reg      [MaxTasks];

    logic [TotW-1:0]  total_reg;
    logic [TimeW-1:0] now_reg;
    logic             cur_v_reg;
    logic [SlotW-1:0] cur_reg;

    logic [SlotW-1:0] i;
    logic [SlotW-1:0] h;
    logic [TimeW-1:0] adv_dl;
    logic [TotW-1:0]  sum;

    assign i         = idx_reg[SlotW-1:0];
    assign h         = hit_slot_reg;
    assign cmd_ready = (state_reg == E_IDLE);
    assign res_valid = (state_reg == E_OUT);
    assign res_data  = res_reg;
    assign adv_dl    = dl_reg[h] + TimeW'(per_reg[h]);
    assign sum       = total_reg + TotW'(c_reg.util);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            total_reg <= '0;
            now_reg   <= '0;
            cur_v_reg <= 1'b0;
            cur_reg   <= '0;
            for (int k = 0; k < MaxTasks; k++) begin
                valid_reg[k]   <= 1'b0;
                started_reg[k] <= 1'b0;
                armed_reg[k]   <= 1'b0;
                mode_reg[k]    <= MODE_SLEEP;
            end
        end else begin
            case (state_reg)
                E_IDLE: begin
                    if (cmd_valid) begin
                        c_reg   <= cmd;
                        idx_reg <= '0;
                        hit_reg <= 1'b0;
                        free_reg <= 1'b0;
                        st_reg  <= ST_OK;
                        if (cmd.op == OP_TICK) now_reg <= now_reg + 1'b1;
                        state_reg <= E_SCAN;
                    end
                end
                E_SCAN: begin
                    // one slot per cycle: lookup, free slot, tick wake
                    if (c_reg.op == OP_TICK) begin
                        if (valid_reg[i] && armed_reg[i] && dl_reg[i] <= now_reg) begin
                            armed_reg[i] <= 1'b0;
                            mode_reg[i]  <= MODE_READY;
                        end
                    end
                    if (!hit_reg && valid_reg[i] && id_reg[i] == c_reg.task_id) begin
                        hit_reg <= 1'b1;
                        hit_slot_reg <= i;
                    end
                    if (!free_reg && !valid_reg[i]) begin
                        free_reg <= 1'b1;
                        free_slot_reg <= i;
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == (SlotW+1)'(MaxTasks-1)) state_reg <= E_EXEC;
                end
                E_EXEC: begin
                    case (c_reg.op)
                        OP_REG: begin
                            if (c_reg.zero_period) st_reg <= ST_ZERO;
                            else if (sum > TotW'(util_bound)) st_reg <= ST_REFUSED;
                            else if (!free_reg) st_reg <= ST_FULL;
                            else begin
                                valid_reg[free_slot_reg]   <= 1'b1;
                                id_reg[free_slot_reg]      <= c_reg.task_id;
                                per_reg[free_slot_reg]     <= c_reg.period;
                                util_reg[free_slot_reg]    <= c_reg.util;
                                dl_reg[free_slot_reg]      <= '0;
                                started_reg[free_slot_reg] <= 1'b0;
                                armed_reg[free_slot_reg]   <= 1'b0;
                                mode_reg[free_slot_reg]    <= MODE_SLEEP;
                                total_reg <= sum;
                            end
                        end
                        OP_YIELD: begin
                            if (!hit_reg) st_reg <= ST_NOTFOUND;
                            else begin
                                if (cur_v_reg && cur_reg == h) begin
                                    cur_v_reg <= 1'b0;
                                    cur_reg   <= '0;
                                end
                                mode_reg[h] <= MODE_SLEEP;
                                if (!started_reg[h]) begin
                                    dl_reg[h]      <= now_reg + TimeW'(per_reg[h]);
                                    started_reg[h] <= 1'b1;
                                    armed_reg[h]   <= 1'b1;
                                end else begin
                                    dl_reg[h] <= adv_dl;
                                    if (adv_dl < now_reg) begin
                                        armed_reg[h] <= 1'b0;
                                        st_reg <= ST_LATE;
                                    end else begin
                                        armed_reg[h] <= 1'b1;
                                    end
                                end
                            end
                        end
                        OP_DEREG: begin
                            if (!hit_reg) st_reg <= ST_NOTFOUND;
                            else begin
                                if (cur_v_reg && cur_reg == h) begin
                                    cur_v_reg <= 1'b0;
                                    cur_reg   <= '0;
                                end
                                total_reg      <= total_reg - TotW'(util_reg[h]);
                                valid_reg[h]   <= 1'b0;
                                armed_reg[h]   <= 1'b0;
                                started_reg[h] <= 1'b0;
                                mode_reg[h]    <= MODE_SLEEP;
                            end
                        end
                        default: ;
                    endcase
                    idx_reg  <= '0;
                    best_reg <= 1'b0;
                    state_reg <= E_DISP;
                end
                E_DISP: begin
                    // shortest period among ready tasks, lowest slot on ties
                    if (valid_reg[i] && mode_reg[i] == MODE_READY &&
                        (!best_reg || per_reg[i] < best_per_reg)) begin
                        best_reg      <= 1'b1;
                        best_slot_reg <= i;
                        best_per_reg  <= per_reg[i];
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == (SlotW+1)'(MaxTasks-1)) state_reg <= E_PICK;
                end
                E_PICK: begin
                    sw_reg <= 1'b0;
                    if (best_reg && (!cur_v_reg || best_per_reg < per_reg[cur_reg])) begin
                        if (cur_v_reg) mode_reg[cur_reg] <= MODE_READY;
                        mode_reg[best_slot_reg] <= MODE_RUN;
                        cur_v_reg <= 1'b1;
                        cur_reg   <= best_slot_reg;
                        sw_reg    <= 1'b1;
                    end
                    state_reg <= E_OUT;
                end
                E_OUT: begin
                    if (res_ready) state_reg <= E_IDLE;
                end
                default: state_reg <= E_IDLE;
            endcase
        end
    end

    // result: status, running_valid, running_id, switched
    always_comb begin
        res_reg = {5'd0, sw_reg, (cur_v_reg ? id_reg[cur_reg] : {IdW{1'b0}}),
                   cur_v_reg, st_reg};
    end

    a_cur_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == E_OUT && cur_v_reg) |-> valid_reg[cur_reg])
        else $error("running slot not valid");
    a_cur_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == E_OUT && cur_v_reg) |-> (mode_reg[cur_reg] == MODE_RUN))
        else $error("running slot not in run mode");
    a_sw: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == E_OUT && sw_reg) |-> cur_v_reg)
        else $error("switch without running task");
endmodule

// File: design/rate_monotonic_task_scheduler.sv
// Rate-monotonic task scheduler: one result per item.
// Path: front end (bit-serial admission divide for a register item), queue, then
// the engine's two 16-slot table sweeps. The front end and queue overlap the
// engine, so a new item can be taken before the last result is out, and a
// stalled result holds the engine.
// Reset (aresetn low, synchronous) empties the table, zeroes time and utilization, loads 6930.
module rate_monotonic_task_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] opcode, [23:2] task_id, [39:24] period, [55:40] compute_ms
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] status, [3] running_valid, [25:4] running_id, [26] switched
    output logic [31:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rms_pkg::*;

    localparam logic [1:0] AddrBound = 2'd0;

    logic [BoundW-1:0] bound_reg;
    logic              fq_valid, fq_ready, qe_valid, qe_ready;
    cmd_t              fq_cmd, qe_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr == AddrBound) ? {18'd0, bound_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bound_reg <= UtilReset;
        end else if (psel && penable && pwrite && paddr == AddrBound) begin
            bound_reg <= pwdata[BoundW-1:0];
        end
    end

    rms_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tdata[1:0]),
        .in_id     (s_tdata[23:2]),
        .in_period (s_tdata[39:24]),
        .in_comp   (s_tdata[55:40]),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd       (fq_cmd)
    );

    rms_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_cmd),
        .rd_valid (qe_valid),
        .rd_ready (qe_ready),
        .rd_data  (qe_cmd)
    );

    rms_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .util_bound (bound_reg),
        .cmd_valid  (qe_valid),
        .cmd_ready  (qe_ready),
        .cmd        (qe_cmd),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_data   (m_tdata)
    );
endmodule

// File: dv/rate_monotonic_task_scheduler_tb.sv
// Testbench for rate_monotonic_task_scheduler: drives task operations over the
// stream input, predicts every result with a table model, checks the output.
// Depends on rms_pkg and the scheduler RTL.
`timescale 1ns / 100ps

module rate_monotonic_task_scheduler_tb;
    import rms_pkg::*;

    localparam logic [1:0] AddrBound = 2'd0;

    typedef struct packed {
        logic [2:0]  status;
        logic        run_valid;
        logic [21:0] run_id;
        logic        switched;
    } sched_result_t;

    class sched_scoreboard;
        logic [13:0] bound;
        bit          used[16];
        logic [21:0] id[16];
        logic [15:0] per[16];
        logic [29:0] utl[16];
        logic [47:0] dl[16];
        bit          started[16];
        bit          armed[16];
        mode_t       mode[16];
        logic [34:0] total;
        logic [47:0] now;
        bit          cur_v;
        int          cur;
        sched_result_t pending[$];
        int          errors;

        function void clear();
            bound = UtilReset;
            for (int i = 0; i < 16; i++) begin
                used[i] = 0; started[i] = 0; armed[i] = 0; mode[i] = MODE_SLEEP;
                id[i] = 0; per[i] = 0; utl[i] = 0; dl[i] = 0;
            end
            total = 0; now = 0; cur_v = 0; cur = 0;
        endfunction

        function int lookup(logic [21:0] tid);
            for (int i = 0; i < 16; i++)
                if (used[i] && id[i] == tid) return i;
            return -1;
        endfunction

        function void note_item(op_t op, logic [21:0] tid, logic [15:0] p,
                                logic [15:0] c);
            status_t st;
            int s;
            int best;
            logic [29:0] u;
            bit sw;
            sched_result_t r;
            st = ST_OK;
            sw = 0;
            best = -1;
            case (op)
                OP_REG: begin
                    if (p == 0) st = ST_ZERO;
                    else begin
                        u = 30'((64'(c) * 10000) / p);
                        if (64'(total) + u > bound) st = ST_REFUSED;
                        else begin
                            s = -1;
                            for (int i = 0; i < 16; i++)
                                if (!used[i] && s < 0) s = i;
                            if (s < 0) st = ST_FULL;
                            else begin
                                used[s] = 1; id[s] = tid; per[s] = p; utl[s] = u;
                                dl[s] = 0; started[s] = 0; armed[s] = 0;
                                mode[s] = MODE_SLEEP; total += u;
                            end
                        end
                    end
                end
                OP_YIELD: begin
                    s = lookup(tid);
                    if (s < 0) st = ST_NOTFOUND;
                    else begin
                        if (cur_v && cur == s) begin cur_v = 0; cur = 0; end
                        mode[s] = MODE_SLEEP;
                        if (!started[s]) begin
                            dl[s] = now + per[s]; started[s] = 1; armed[s] = 1;
                        end else begin
                            dl[s] = dl[s] + per[s];
                            armed[s] = !(dl[s] < now);
                            if (dl[s] < now) st = ST_LATE;
                        end
                    end
                end
                OP_DEREG: begin
                    s = lookup(tid);
                    if (s < 0) st = ST_NOTFOUND;
                    else begin
                        if (cur_v && cur == s) begin cur_v = 0; cur = 0; end
                        total -= utl[s];
                        used[s] = 0; armed[s] = 0; started[s] = 0; mode[s] = MODE_SLEEP;
                    end
                end
                default: begin
                    now = now + 1;
                    for (int i = 0; i < 16; i++)
                        if (used[i] && armed[i] && dl[i] <= now) begin
                            armed[i] = 0; mode[i] = MODE_READY;
                        end
                end
            endcase
            for (int i = 0; i < 16; i++)
                if (used[i] && mode[i] == MODE_READY)
                    if (best < 0 || per[i] < per[best]) best = i;
            if (best >= 0 && (!cur_v || per[best] < per[cur])) begin
                if (cur_v) mode[cur] = MODE_READY;
                mode[best] = MODE_RUN; cur_v = 1; cur = best; sw = 1;
            end
            r.status = st;
            r.run_valid = cur_v;
            r.run_id = cur_v ? id[cur] : '0;
            r.switched = sw;
            pending.push_back(r);
        endfunction

        function void check_result(logic [31:0] d);
            sched_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: result %h with none expected", $time, d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[2:0] != e.status) begin
                $display("%0t: status exp %0d got %0d", $time, e.status, d[2:0]);
                errors++;
            end
            if (d[3] != e.run_valid) begin
                $display("%0t: running_valid exp %0d got %0d", $time, e.run_valid, d[3]);
                errors++;
            end
            if (d[25:4] != e.run_id) begin
                $display("%0t: running_id exp %h got %h", $time, e.run_id, d[25:4]);
                errors++;
            end
            if (d[26] != e.switched) begin
                $display("%0t: switched exp %0d got %0d", $time, e.switched, d[26]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sched_scoreboard sb = new();
    bit          stall_mode;
    logic [21:0] ids[8];

    rate_monotonic_task_scheduler dut (.*);

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    // Receiver: stall pattern switches between free-running and random stalls.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if ($urandom_range(0, 63) == 0) stall_mode <= !stall_mode;
            m_tready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    task automatic send_item(op_t op, logic [21:0] tid, logic [15:0] p, logic [15:0] c);
        s_tvalid <= 1;
        s_tdata <= {c, p, tid, op};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(op, tid, p, c);
    endtask

    task automatic idle_gap();
        s_tvalid <= 0;
        repeat ($urandom_range(1, 30)) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_bound(logic [13:0] v);
        psel <= 1; pwrite <= 1; paddr <= AddrBound; pwdata <= {18'd0, v};
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.bound = v;
        @(posedge aclk);
    endtask

    task automatic random_item();
        int k;
        logic [21:0] tid;
        logic [15:0] p, c;
        k = $urandom_range(0, 99);
        tid = ($urandom_range(0, 9) == 0) ? 22'($urandom) : ids[$urandom_range(0, 7)];
        p = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 40));
        c = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        if ($urandom_range(0, 29) == 0) p = '0;
        if (k < 15) send_item(OP_REG, tid, p, c);
        else if (k < 40) send_item(OP_YIELD, tid, p, c);
        else if (k < 47) send_item(OP_DEREG, tid, p, c);
        else send_item(OP_TICK, 22'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial begin
        logic [13:0] bounds[4];
        bounds = '{14'd10000, 14'd0, 14'd16383, 14'd5000};
        sb.clear();
        stall_mode = 0;
        for (int i = 0; i < 8; i++) ids[i] = 22'($urandom);
        ids[0] = '0; ids[1] = 22'h3FFFFF;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // Directed: extremes, zero period, refusal, full table, late deadline.
        send_item(OP_REG, ids[0], 16'd0, 16'd5);
        send_item(OP_REG, ids[1], 16'd1, 16'hFFFF);
        send_item(OP_REG, ids[1], 16'hFFFF, 16'd0);
        send_item(OP_REG, ids[2], 16'd3, 16'd1);
        send_item(OP_YIELD, ids[2], 16'hFFFF, 16'hFFFF);
        send_item(OP_YIELD, ids[1], '0, '0);
        for (int i = 0; i < 4; i++) send_item(OP_TICK, 22'h3FFFFF, 16'hFFFF, 16'hFFFF);
        send_item(OP_YIELD, ids[3], '0, '0);
        send_item(OP_DEREG, ids[4], '0, '0);
        drain();
        write_bound(14'd10000);
        for (int i = 0; i < 16; i++) send_item(OP_REG, 22'(i + 5), 16'(i + 2), 16'd0);
        send_item(OP_YIELD, 22'd5, '0, '0);
        for (int i = 0; i < 5; i++) send_item(OP_TICK, '0, '0, '0);
        send_item(OP_YIELD, 22'd5, '0, '0);
        send_item(OP_YIELD, 22'd5, '0, '0);
        for (int i = 0; i < 16; i++) send_item(OP_DEREG, 22'(i + 5), '0, '0);
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            write_bound(bounds[ph]);
            for (int n = 0; n < 200; ) begin
                for (int b = $urandom_range(1, 12); b > 0 && n < 200; b--, n++)
                    random_item();
                if ($urandom_range(0, 2) != 0) idle_gap();
            end
            drain();
        end
        if (sb.errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    initial begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
